@@ hdl/bitmap_first_free_allocator_defines.svh @@
// Assertion macros used by the checker file of the bitmap allocator.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BFFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bffa_pkg.sv @@
// Package with the codes and field widths of the bitmap allocator.
package bffa_pkg;

	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 10;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 15;
	localparam int BLOCK_W  = 32;
	localparam int COUNT_W  = 16;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_FOUND  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd2;

	localparam logic REG_REGION_START = 1'b0;
	localparam logic REG_REGION_COUNT = 1'b1;

endpackage

@@ hdl/bitmap_first_free_allocator.sv @@
// Top level of the first-fit allocator over a free-space bitmap held in one memory.
// The bitmap sits in a single-port-read, single-port-write memory of WORD_BITS-bit words.
// One request is handled at a time. A load passes from acceptance straight to the response
// state, a read passes through a read-wait state, and an allocate or find request passes
// through the scan state, which reads N words, one word per cycle through the memory's
// read port, so N is at most ceil(min(region_count, BITMAP_BITS) / WORD_BITS), and a zero
// count costs no word. From the response state the result moves into the output register.
// A new word is accepted in the cycle after the previous result has moved into the
// output register, even if that result is not yet taken; a result that finds the output
// register still full waits until that register is taken, and the input stays closed
// meanwhile. The bitmap has no reset; every word must be loaded before it is searched or
// read.
module bitmap_first_free_allocator import bffa_pkg::*; #(
	parameter int BITMAP_BITS = 32768,
	parameter int WORD_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // word_index[9:0], word_data[41:10], zero pad
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // entry_index[14:0], block_number[46:15],
	                                   // read_data[78:47], zero pad
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int NUM_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int LW = ($clog2(BITMAP_BITS + 1) > COUNT_W + 1) ?
		$clog2(BITMAP_BITS + 1) : COUNT_W + 1;
	localparam int BW = $clog2(WORD_BITS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RDWAIT = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	logic [1:0]           state_q;
	logic [DATA_W-1:0]    region_start_q;
	logic [COUNT_W-1:0]   region_count_q;

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [WORD_BITS-1:0] rd_word_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	logic [KIND_W-1:0]    in_kind;
	logic [INDEX_W-1:0]   in_index;
	logic [DATA_W-1:0]    in_data;
	logic [IW:0]          index_ext;
	logic                 index_ok;
	logic [AW-1:0]        index_addr;
	logic                 accept;
	logic                 is_search;
	logic [LW-1:0]        count_ext;
	logic [LW-1:0]        limit;

	logic [LW-1:0]        limit_q;
	logic [LW-1:0]        base_q;
	logic [AW-1:0]        wptr_q;
	logic                 alloc_q;
	logic                 index_ok_q;

	logic [LW-1:0]        remain;
	logic [WORD_BITS-1:0] valid_mask;
	logic [WORD_BITS-1:0] clear;
	logic                 hit;
	logic [BW-1:0]        hit_pos;
	logic [LW-1:0]        hit_idx;
	logic                 last_word;
	logic [WORD_BITS-1:0] set_word;

	logic [STATUS_W-1:0]  res_status_q;
	logic [ENTRY_W-1:0]   res_entry_q;
	logic [BLOCK_W-1:0]   res_block_q;
	logic [DATA_W-1:0]    res_read_q;

	logic                 m_valid_q;
	logic                 push;
	logic [STATUS_W-1:0]  m_status_q;
	logic [ENTRY_W-1:0]   m_entry_q;
	logic [BLOCK_W-1:0]   m_block_q;
	logic [DATA_W-1:0]    m_read_q;

	assign in_kind    = s_axis_tuser;
	assign in_index   = s_axis_tdata[INDEX_W-1:0];
	assign in_data    = s_axis_tdata[INDEX_W+DATA_W-1:INDEX_W];
	assign index_ext  = (IW + 1)'(in_index);
	assign index_ok   = index_ext < (IW + 1)'(NUM_WORDS);
	assign index_addr = index_ext[AW-1:0];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_search     = (in_kind == KIND_ALLOC) || (in_kind == KIND_FIND);

	assign count_ext = LW'(region_count_q);
	assign limit     = (count_ext > LW'(BITMAP_BITS)) ? LW'(BITMAP_BITS) : count_ext;

	assign remain = limit_q - base_q;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			valid_mask[b] = LW'(b) < remain;
		end
	end

	assign clear = ~rd_word_q & valid_mask;

	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (clear[b]) begin
				hit     = 1'b1;
				hit_pos = BW'(b);
			end
		end
	end

	assign hit_idx   = base_q + LW'(hit_pos);
	assign last_word = (base_q + LW'(WORD_BITS)) >= limit_q;
	assign set_word  = rd_word_q | (WORD_BITS'(1) << hit_pos);

	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = is_search ? '0 : index_addr;
			ST_SCAN: rd_addr = wptr_q + AW'(1);
			default: rd_addr = wptr_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = index_addr;
		wr_data = WORD_BITS'(in_data);
		if (accept && in_kind == KIND_LOAD && index_ok) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SCAN && hit && alloc_q) begin
			wr_en   = 1'b1;
			wr_addr = wptr_q;
			wr_data = set_word;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_word_q <= mem[rd_addr];
	end

	assign push = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			m_valid_q      <= 1'b0;
			region_start_q <= '0;
			region_count_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REGION_START: region_start_q <= cfg_data;
					REG_REGION_COUNT: region_count_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_kind == KIND_LOAD) begin
							state_q <= ST_RESP;
						end else if (in_kind == KIND_READ) begin
							state_q <= ST_RDWAIT;
						end else if (limit == '0) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_RDWAIT: state_q <= ST_RESP;
				ST_SCAN: begin
					if (hit || last_word) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				limit_q      <= limit;
				base_q       <= '0;
				wptr_q       <= '0;
				alloc_q      <= (in_kind == KIND_ALLOC);
				index_ok_q   <= index_ok;
				res_status_q <= (in_kind == KIND_LOAD || in_kind == KIND_READ) ?
					STATUS_DONE : STATUS_NOFREE;
				res_entry_q  <= '0;
				res_block_q  <= '0;
				res_read_q   <= '0;
			end
			ST_RDWAIT: begin
				res_read_q <= index_ok_q ? DATA_W'(rd_word_q) : '0;
			end
			ST_SCAN: begin
				base_q <= base_q + LW'(WORD_BITS);
				wptr_q <= wptr_q + AW'(1);
				if (hit) begin
					res_status_q <= STATUS_FOUND;
					res_entry_q  <= hit_idx[ENTRY_W-1:0];
					res_block_q  <= region_start_q + BLOCK_W'(hit_idx);
				end
			end
			default: ;
		endcase
		if (push) begin
			m_status_q <= res_status_q;
			m_entry_q  <= res_entry_q;
			m_block_q  <= res_block_q;
			m_read_q   <= res_read_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {1'b0, m_read_q, m_block_q, m_entry_q};

endmodule

@@ hdl/bffa_checker.sv @@
// Port-level checker for the bitmap allocator and its bind to the top level.
`include "bitmap_first_free_allocator_defines.svh"

module bffa_checker import bffa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// One request is in flight at a time, so acceptance closes the input side.
	`BFFA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "input accepted while a request is in flight")

	`BFFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result word changed")

	`BFFA_ASSERT_NOW(a_no_index_unless_found, m_axis_tvalid && m_axis_tuser != STATUS_FOUND,
		m_axis_tdata[46:0] == 47'd0, "index or block number without a found entry")

	`BFFA_ASSERT_NOW(a_read_only_done, m_axis_tvalid && m_axis_tuser != STATUS_DONE,
		m_axis_tdata[78:47] == 32'd0, "read data outside a read result")

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);

@@ tb/bitmap_first_free_allocator_tb.sv @@
// Self-checking testbench for the first-fit bitmap allocator with directed and random traffic.
`timescale 1ns / 1ps
module bitmap_first_free_allocator_tb;
	import bffa_pkg::*;

	localparam int MAP_BITS      = 32768;
	localparam int WORD_W        = 32;
	localparam int MAP_WORDS     = MAP_BITS / WORD_W;
	localparam int LONG_WORDS    = 160;
	localparam int LONG_BITS     = LONG_WORDS * WORD_W;
	localparam int STUCK_LIMIT   = 8000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS   = 38;
	localparam int MAX_PRINTED   = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  entry_index;
		logic [BLOCK_W-1:0]  block_number;
		logic [DATA_W-1:0]   read_data;
	} alloc_answer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;  // word_index[9:0], word_data[41:10], zero pad
	logic [1:0]  s_axis_tuser;  // kind[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;  // entry_index[14:0], block_number[46:15],
	                            // read_data[78:47], zero pad
	logic [1:0]  m_axis_tuser;  // status[1:0]

	logic [WORD_W-1:0]  bitmap_shadow [MAP_WORDS];
	bit                 word_loaded [MAP_WORDS];
	logic [31:0]        start_shadow;
	logic [COUNT_W-1:0] count_shadow;
	alloc_answer_t      pending_answers [$];

	bit tx_quiet;
	bit rx_quiet;
	int error_count;
	int found_count;
	int nofree_count;
	int done_count;
	int setting_count;
	int stuck_cycles;

	bitmap_first_free_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic alloc_answer_t allocator_answer(logic [KIND_W-1:0] kind,
			logic [INDEX_W-1:0] widx, logic [DATA_W-1:0] wdata);
		alloc_answer_t     r;
		int unsigned       limit;
		int unsigned       base;
		int unsigned       w;
		int unsigned       b;
		logic [WORD_W-1:0] clear;
		bit                hit;
		r = '0;
		r.status = STATUS_DONE;
		if (kind == KIND_LOAD) begin
			bitmap_shadow[widx] = wdata;
			word_loaded[widx] = 1'b1;
		end else if (kind == KIND_READ) begin
			r.read_data = bitmap_shadow[widx];
		end else begin
			limit = (count_shadow > MAP_BITS) ? MAP_BITS : count_shadow;
			hit = 1'b0;
			r.status = STATUS_NOFREE;
			for (w = 0; w < MAP_WORDS; w++) begin
				base = w * WORD_W;
				if (base >= limit)
					break;
				clear = ~bitmap_shadow[w];
				if (limit - base < WORD_W)
					clear = clear & ((WORD_W'(1) << (limit - base)) - WORD_W'(1));
				for (b = 0; b < WORD_W && !hit; b++) begin
					if (clear[b]) begin
						hit = 1'b1;
						r.status = STATUS_FOUND;
						r.entry_index = ENTRY_W'(base + b);
						r.block_number = start_shadow + (base + b);
						if (kind == KIND_ALLOC)
							bitmap_shadow[w][b] = 1'b1;
					end
				end
				if (hit)
					break;
			end
		end
		return r;
	endfunction

	// Returns the first word a search would read before it was ever loaded, or -1.
	function automatic int first_unloaded_in_reach();
		int unsigned       limit;
		int unsigned       base;
		int unsigned       w;
		logic [WORD_W-1:0] clear;
		limit = (count_shadow > MAP_BITS) ? MAP_BITS : count_shadow;
		for (w = 0; w < MAP_WORDS; w++) begin
			base = w * WORD_W;
			if (base >= limit)
				return -1;
			if (!word_loaded[w])
				return int'(w);
			clear = ~bitmap_shadow[w];
			if (limit - base < WORD_W)
				clear = clear & ((WORD_W'(1) << (limit - base)) - WORD_W'(1));
			if (clear != '0)
				return -1;
		end
		return -1;
	endfunction

	function automatic logic [DATA_W-1:0] random_map_word();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: v = '1;
		4, 5: v = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
		6: v = '0;
		default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("Mismatch in %s at %0t: expected %h, got %h",
				field, $time, want, got);
	endtask

	task automatic send_word(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] widx,
			logic [DATA_W-1:0] wdata);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, wdata, widx};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		pending_answers.push_back(allocator_answer(kind, widx, wdata));
		@(negedge clk);
	endtask

	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_REGION_START)
			start_shadow = value;
		else
			count_shadow = value[COUNT_W-1:0];
	endtask

	task automatic apply_settings(logic [31:0] start, logic [COUNT_W-1:0] count);
		drain_block();
		if ($urandom_range(0, 1) == 0) begin
			write_register(REG_REGION_START, start);
			write_register(REG_REGION_COUNT, {16'b0, count});
		end else begin
			write_register(REG_REGION_COUNT, {16'b0, count});
			write_register(REG_REGION_START, start);
		end
		setting_count++;
	endtask

	task automatic test_directed_cases();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_FIND, '1, '1);
		send_word(KIND_LOAD, '0, 32'hFFFF_FFFE);
		send_word(KIND_LOAD, 10'd1, '0);
		send_word(KIND_LOAD, '1, '1);
		send_word(KIND_READ, '0, '0);
		send_word(KIND_READ, 10'd1, '1);
		send_word(KIND_READ, '1, '0);
		apply_settings(32'hFFFF_FFFF, 16'd1);
		send_word(KIND_FIND, '0, '0);
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_READ, '0, '0);
		apply_settings(32'h0000_1000, 16'd33);
		send_word(KIND_FIND, '0, '0);
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_LOAD, '0, 32'h7FFF_FFFF);
		send_word(KIND_FIND, '0, '0);
		send_word(KIND_LOAD, '0, '1);
		send_word(KIND_LOAD, 10'd1, '1);
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_LOAD, 10'd1, 32'hAAAA_AAAA);
		send_word(KIND_ALLOC, '0, '0);
		send_word(KIND_READ, 10'd1, '0);
	endtask

	// Fills the low part of the map so that searches run across many full words.
	task automatic test_long_scan();
		int w;
		for (w = 0; w < LONG_WORDS; w++)
			send_word(KIND_LOAD, w[INDEX_W-1:0],
				(w == LONG_WORDS - 1) ? 32'h7FFF_FFFF : '1);
		apply_settings(32'hFFFF_FFFF, 16'(MAP_BITS));
		send_word(KIND_FIND, '0, '0);
		send_word(KIND_ALLOC, '0, '0);
		apply_settings(32'h0000_8000, 16'(LONG_BITS));
		send_word(KIND_FIND, '0, '0);
		send_word(KIND_LOAD, 10'(LONG_WORDS - 1), 32'h7FFF_FFFF);
		apply_settings(32'h0000_0000, 16'(LONG_BITS - 1));
		send_word(KIND_FIND, '0, '0);
		apply_settings(32'h0000_0010, 16'hFFFF);
		send_word(KIND_FIND, '0, '0);
		send_word(KIND_READ, 10'(LONG_WORDS - 1), '0);
	endtask

	task automatic test_random_traffic();
		int                 phase;
		int                 n;
		int                 span;
		int                 pick;
		int                 gap_word;
		logic [INDEX_W-1:0] widx;
		logic [COUNT_W-1:0] count;
		logic [31:0]        start;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
			0: count = '0;
			1: count = 16'(MAP_BITS);
			2: count = COUNT_W'($urandom_range(MAP_BITS + 1, 65535));
			3: count = 16'(MAP_BITS - 1);
			default: count = COUNT_W'($urandom_range(1, 640));
			endcase
			case ($urandom_range(0, 4))
			0: start = '0;
			1: start = '1;
			2: start = 32'hFFFF_FFFF - $urandom_range(0, 700);
			default: start = $urandom;
			endcase
			apply_settings(start, count);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			span = (count + WORD_W - 1) / WORD_W;
			if (span > MAP_WORDS)
				span = MAP_WORDS;
			if (span == 0)
				span = 1;
			for (n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 19);
				if (pick < 11) begin
					gap_word = first_unloaded_in_reach();
					while (gap_word >= 0) begin
						send_word(KIND_LOAD, gap_word[INDEX_W-1:0], random_map_word());
						gap_word = first_unloaded_in_reach();
					end
					if (pick < 8)
						send_word(KIND_ALLOC, INDEX_W'($urandom), $urandom);
					else
						send_word(KIND_FIND, INDEX_W'($urandom), $urandom);
				end else if (pick < 17) begin
					widx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom) :
						INDEX_W'($urandom_range(0, span - 1));
					send_word(KIND_LOAD, widx, random_map_word());
				end else begin
					widx = INDEX_W'($urandom);
					if (!word_loaded[widx])
						widx = INDEX_W'($urandom_range(0, LONG_WORDS - 1));
					send_word(KIND_READ, widx, $urandom);
				end
			end
		end
	endtask

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		alloc_answer_t seen;
		alloc_answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = {m_axis_tuser, m_axis_tdata[14:0], m_axis_tdata[46:15],
				m_axis_tdata[78:47]};
			if (pending_answers.size() == 0) begin
				report_mismatch("word with nothing expected", '0, 32'(seen.status));
			end else begin
				want = pending_answers.pop_front();
				if (seen.status != want.status)
					report_mismatch("status", 32'(want.status), 32'(seen.status));
				if (seen.entry_index != want.entry_index)
					report_mismatch("entry_index", 32'(want.entry_index),
						32'(seen.entry_index));
				if (seen.block_number != want.block_number)
					report_mismatch("block_number", want.block_number, seen.block_number);
				if (seen.read_data != want.read_data)
					report_mismatch("read_data", want.read_data, seen.read_data);
				if (want.status == STATUS_FOUND)
					found_count++;
				else if (want.status == STATUS_NOFREE)
					nofree_count++;
				else
					done_count++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", stuck_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_REGION_START;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = KIND_LOAD;
		start_shadow  = '0;
		count_shadow  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_long_scan();
		test_random_traffic();
		drain_block();
		repeat (16) @(negedge clk);
		$display("Covered %0d entries found and %0d no-free answers across %0d settings,",
			found_count, nofree_count, setting_count);
		$display("plus %0d bitmap loads and readbacks, with %0d mismatches.",
			done_count, error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
